/* hdl/bsrs_pkg.sv */
package bsrs_pkg;

	// window geometry; the mean is a shift, so the depth stays a power of two
	localparam int WINDOW_DEPTH = 16;
	localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

	localparam int VAL_W  = 17;
	localparam int SUM_W  = VAL_W + WIN_AW;
	localparam int BASE_W = 10;
	localparam int CNT_W  = 16;
	localparam int OP_W   = 2;
	localparam int DIV_CW = $clog2(VAL_W + 1);

	localparam int IN_TDATA_W  = 24;
	localparam int IN_TUSER_W  = OP_W;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_TUSER_W = 1;
	localparam int CFG_IW      = 2;
	localparam int CFG_DW      = 16;

	localparam logic [VAL_W-1:0]  VAL_MAX      = {VAL_W{1'b1}};
	localparam logic [BASE_W-1:0] DEFAULT_BASE = 10'd100;

	// charge levels in percent that pick the ramp slope
	localparam logic [6:0] LEVEL_LO = 7'd80;
	localparam logic [6:0] LEVEL_HI = 7'd90;

	// reciprocals for n/3 and n/5, exact over 16-bit n
	localparam logic [16:0] RECIP3    = 17'd43691;
	localparam int          RECIP3_SH = 17;
	localparam logic [16:0] RECIP5    = 17'd52429;
	localparam int          RECIP5_SH = 18;
	localparam logic [1:0]  RAMP_OFS  = 2'd3;

	// product width covers the widest quotient select
	localparam int PROD_W = CNT_W + RECIP5_SH;

	typedef enum logic [OP_W-1:0] {
		OP_START,
		OP_TICK,
		OP_STOP,
		OP_QUERY
	} op_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_BASE_SCALE,
		CFG_RAMP_SAMPLES,
		CFG_PROFILE_SEL
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FILL,
		ST_TRD,
		ST_TRAMP,
		ST_TUPD,
		ST_DIVGO,
		ST_DIVWAIT,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic set_started;
		logic fill_init;
		logic fill_we;
		logic rd;
		logic ramp;
		logic upd;
		logic sel_gauge;
		logic div_start;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic started;
		logic profile;
		logic active;
		logic pending;
		logic fill_last;
		logic div_busy;
		logic out_free;
	} dp_sts_t;

endpackage

/* hdl/battery_soc_ramp_smoother.sv */
// Battery charge ramp smoother.
// Input stream (s_*): one beat per command. s_tuser carries the op (start, tick,
// stop, query), s_tdata the scaled gauge reading. Every beat yields exactly one
// result beat on m_*: the reported scaled charge, that value split into whole
// percent and fraction by the effective base, and the ramp-done flag in m_tuser.
// Config channel (cfg_*): base scale, ramp sample count, profile select;
// always ready; the user must write it only while no beat is in work, unchecked by the block.
// Flow: one beat is in work at a time. Every beat passes decode and an iterative
// divider (one quotient bit per cycle); a ramp tick adds a window read, ramp and
// window update, a start that fills the 16-entry window adds that fill first.
// The output register decouples the sides: a finished result waits there
// while the next beat is accepted and worked; only a second finished result
// stalls the core until the first is taken.
// Reset (arst_n low) clears the window valid bits, sums, counters and
// flags at once; no clearing pass is needed.
module battery_soc_ramp_smoother (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bsrs_pkg::IN_TDATA_W-1:0]  s_tdata,  // [16:0] gauge_reading
	input  logic [bsrs_pkg::IN_TUSER_W-1:0]  s_tuser,  // [1:0] op
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [16:0] soc_value, [33:17] whole_percent, [43:34] fraction_part
	output logic [bsrs_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [bsrs_pkg::OUT_TUSER_W-1:0] m_tuser,  // [0] ramp_done
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bsrs_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [bsrs_pkg::CFG_DW-1:0]      cfg_data
);

	bsrs_pkg::ctrl_cmd_t cmd;
	bsrs_pkg::dp_sts_t   sts;

	// sequencer: decode, window fill sweep, tick steps, divide, emit
	bsrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// window ram, running sum, ramp math, divider, output register
	bsrs_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

/* hdl/bsrs_div.sv */
module bsrs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bsrs_pkg::VAL_W-1:0]  dividend,
	input  logic [bsrs_pkg::BASE_W-1:0] divisor,
	output logic                        busy,
	output logic [bsrs_pkg::VAL_W-1:0]  quotient,
	output logic [bsrs_pkg::BASE_W-1:0] remainder
);

	logic [bsrs_pkg::DIV_CW-1:0] cnt_q;
	logic [bsrs_pkg::VAL_W-1:0]  quo_q;
	logic [bsrs_pkg::BASE_W-1:0] rem_q;
	logic [bsrs_pkg::BASE_W-1:0] dsr_q;
	logic [bsrs_pkg::BASE_W:0]   trial;
	logic                        ge;

	// restoring, one quotient bit per cycle
	assign trial = {rem_q, quo_q[bsrs_pkg::VAL_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= bsrs_pkg::DIV_CW'(bsrs_pkg::VAL_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[bsrs_pkg::VAL_W-2:0], ge};
			rem_q <= ge ? bsrs_pkg::BASE_W'(trial - {1'b0, dsr_q})
			            : trial[bsrs_pkg::BASE_W-1:0];
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* hdl/bsrs_dpath.sv */
module bsrs_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bsrs_pkg::ctrl_cmd_t              cmd,
	output bsrs_pkg::dp_sts_t                sts,
	input  logic [bsrs_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [bsrs_pkg::IN_TUSER_W-1:0]  s_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bsrs_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [bsrs_pkg::CFG_DW-1:0]      cfg_data,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bsrs_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [bsrs_pkg::OUT_TUSER_W-1:0] m_tuser
);

	// config registers
	logic [bsrs_pkg::BASE_W-1:0] base_q;
	logic [bsrs_pkg::CNT_W-1:0]  samples_q;
	logic                        profile_q;
	logic [bsrs_pkg::BASE_W-1:0] eff_base;

	// captured beat
	bsrs_pkg::op_t              op_q;
	logic [bsrs_pkg::VAL_W-1:0] gauge_q;

	// smoother state
	logic [bsrs_pkg::VAL_W-1:0]        win_mem [bsrs_pkg::WINDOW_DEPTH];
	logic [bsrs_pkg::WINDOW_DEPTH-1:0] valid_q;
	logic [bsrs_pkg::SUM_W-1:0]        sum_q;
	logic [bsrs_pkg::WIN_AW-1:0]       slot_q;
	logic [bsrs_pkg::WIN_AW-1:0]       fill_cnt_q;
	logic [bsrs_pkg::CNT_W-1:0]        tick_q;
	logic [bsrs_pkg::VAL_W-1:0]        init_q;
	logic [bsrs_pkg::VAL_W-1:0]        reported_q;
	logic                              started_q;

	// tick pipeline
	logic [bsrs_pkg::VAL_W-1:0]  rd_s1;
	logic                        old_vld_s1;
	logic                        lt_lo_s1;
	logic                        lt_hi_s1;
	logic [bsrs_pkg::PROD_W-1:0] prod3_s1;
	logic [bsrs_pkg::PROD_W-1:0] prod5_s1;
	logic [bsrs_pkg::VAL_W-1:0]  ramp_s2;

	logic [bsrs_pkg::VAL_W-1:0] lo_thr;
	logic [bsrs_pkg::VAL_W-1:0] hi_thr;
	logic [bsrs_pkg::CNT_W-1:0] step;
	logic [bsrs_pkg::VAL_W:0]   ramp_sum;
	logic [bsrs_pkg::VAL_W-1:0] old_val;
	logic [bsrs_pkg::SUM_W-1:0] sum_new;
	logic [bsrs_pkg::VAL_W-1:0] val_mux;

	// divider and output register
	logic                        div_busy;
	logic [bsrs_pkg::VAL_W-1:0]  div_quo;
	logic [bsrs_pkg::BASE_W-1:0] div_rem;
	logic [bsrs_pkg::VAL_W-1:0]  val_q;
	logic                        out_vld_q;
	logic [bsrs_pkg::VAL_W-1:0]  out_soc_q;
	logic [bsrs_pkg::VAL_W-1:0]  out_whole_q;
	logic [bsrs_pkg::BASE_W-1:0] out_frac_q;
	logic                        out_done_q;

	assign cfg_ready = 1'b1;
	assign eff_base  = (base_q == '0) ? bsrs_pkg::DEFAULT_BASE : base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= bsrs_pkg::DEFAULT_BASE;
			samples_q <= '0;
			profile_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == bsrs_pkg::CFG_BASE_SCALE) begin
				base_q <= cfg_data[bsrs_pkg::BASE_W-1:0];
			end
			if (cfg_index == bsrs_pkg::CFG_RAMP_SAMPLES) begin
				samples_q <= cfg_data[bsrs_pkg::CNT_W-1:0];
			end
			if (cfg_index == bsrs_pkg::CFG_PROFILE_SEL) begin
				profile_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= bsrs_pkg::op_t'(s_tuser[bsrs_pkg::OP_W-1:0]);
			gauge_q <= s_tdata[bsrs_pkg::VAL_W-1:0];
		end
	end

	// level thresholds, the scaled values for 80 and 90 percent (level times the base)
	assign lo_thr = bsrs_pkg::VAL_W'(bsrs_pkg::LEVEL_LO) * bsrs_pkg::VAL_W'(eff_base);
	assign hi_thr = bsrs_pkg::VAL_W'(bsrs_pkg::LEVEL_HI) * bsrs_pkg::VAL_W'(eff_base);

	always_comb begin
		priority if (lt_lo_s1) begin
			step = prod3_s1[bsrs_pkg::RECIP3_SH +: bsrs_pkg::CNT_W];
		end else if (lt_hi_s1) begin
			step = tick_q >> 2;
		end else begin
			step = prod5_s1[bsrs_pkg::RECIP5_SH +: bsrs_pkg::CNT_W];
		end
	end

	assign ramp_sum = {1'b0, init_q} + (bsrs_pkg::VAL_W + 1)'(step)
	                + (bsrs_pkg::VAL_W + 1)'(lt_lo_s1 ? bsrs_pkg::RAMP_OFS : 2'd0);

	assign old_val = old_vld_s1 ? rd_s1 : '0;
	assign sum_new = sum_q - bsrs_pkg::SUM_W'(old_val) + bsrs_pkg::SUM_W'(ramp_s2);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			lt_lo_s1 <= init_q < lo_thr;
			lt_hi_s1 <= init_q < hi_thr;
			prod3_s1 <= tick_q * bsrs_pkg::RECIP3;
			prod5_s1 <= tick_q * bsrs_pkg::RECIP5;
		end
		if (cmd.ramp) begin
			ramp_s2 <= ramp_sum[bsrs_pkg::VAL_W] ? bsrs_pkg::VAL_MAX
			                                     : ramp_sum[bsrs_pkg::VAL_W-1:0];
		end
	end

	// window ram: fill sweep or ring write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.fill_we) begin
			win_mem[fill_cnt_q] <= init_q;
		end else if (cmd.upd) begin
			win_mem[slot_q] <= ramp_s2;
		end
		if (cmd.rd) begin
			rd_s1      <= win_mem[slot_q];
			old_vld_s1 <= valid_q[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			sum_q      <= '0;
			slot_q     <= '0;
			fill_cnt_q <= '0;
			tick_q     <= '0;
			init_q     <= '0;
			reported_q <= '0;
			started_q  <= 1'b0;
		end else if (cmd.clear) begin
			valid_q    <= '0;
			sum_q      <= '0;
			slot_q     <= '0;
			fill_cnt_q <= '0;
			tick_q     <= '0;
			init_q     <= '0;
			reported_q <= '0;
			started_q  <= 1'b0;
		end else begin
			if (cmd.set_started) begin
				started_q <= 1'b1;
			end
			if (cmd.fill_init) begin
				init_q     <= gauge_q;
				reported_q <= gauge_q;
				sum_q      <= {gauge_q, {bsrs_pkg::WIN_AW{1'b0}}};
				slot_q     <= '0;
				tick_q     <= '0;
				fill_cnt_q <= '0;
			end
			if (cmd.fill_we) begin
				valid_q[fill_cnt_q] <= 1'b1;
				fill_cnt_q          <= fill_cnt_q + 1'b1;
			end
			if (cmd.upd) begin
				valid_q[slot_q] <= 1'b1;
				sum_q           <= sum_new;
				slot_q          <= slot_q + 1'b1;
				tick_q          <= tick_q + 1'b1;
				reported_q      <= sum_new[bsrs_pkg::SUM_W-1:bsrs_pkg::WIN_AW];
			end
		end
	end

	assign val_mux = cmd.sel_gauge ? gauge_q : reported_q;

	bsrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (val_mux),
		.divisor   (eff_base),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			val_q <= val_mux;
		end
		if (cmd.out_load) begin
			out_soc_q   <= val_q;
			out_whole_q <= div_quo;
			out_frac_q  <= div_rem;
			out_done_q  <= !(started_q && profile_q) || !(tick_q < samples_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0, out_frac_q, out_whole_q, out_soc_q};
	assign m_tuser  = out_done_q;

	assign sts.op        = op_q;
	assign sts.started   = started_q;
	assign sts.profile   = profile_q;
	assign sts.active    = started_q && profile_q;
	assign sts.pending   = tick_q < samples_q;
	assign sts.fill_last = fill_cnt_q == bsrs_pkg::WIN_AW'(bsrs_pkg::WINDOW_DEPTH - 1);
	assign sts.div_busy  = div_busy;
	assign sts.out_free  = !out_vld_q || m_tready;

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (valid_q == '0) && (sum_q == '0) && !started_q)
		else $error("stop left smoother state behind");

endmodule

/* hdl/bsrs_ctrl.sv */
module bsrs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bsrs_pkg::dp_sts_t   sts,
	output bsrs_pkg::ctrl_cmd_t cmd
);

	bsrs_pkg::ctrl_state_t state_q;
	bsrs_pkg::ctrl_state_t state_nx;
	logic                  pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsrs_pkg::ST_IDLE;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == bsrs_pkg::ST_DECODE) begin
				pass_q <= (sts.op == bsrs_pkg::OP_TICK) && !(sts.active && sts.pending);
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bsrs_pkg::ST_IDLE: begin
				if (in_valid) state_nx = bsrs_pkg::ST_DECODE;
			end
			bsrs_pkg::ST_DECODE: begin
				unique case (sts.op)
					bsrs_pkg::OP_START: begin
						state_nx = (!sts.started && sts.profile) ? bsrs_pkg::ST_FILL
						                                         : bsrs_pkg::ST_DIVGO;
					end
					bsrs_pkg::OP_TICK: begin
						state_nx = (sts.active && sts.pending) ? bsrs_pkg::ST_TRD
						                                       : bsrs_pkg::ST_DIVGO;
					end
					default: state_nx = bsrs_pkg::ST_DIVGO;
				endcase
			end
			bsrs_pkg::ST_FILL: begin
				if (sts.fill_last) state_nx = bsrs_pkg::ST_DIVGO;
			end
			bsrs_pkg::ST_TRD:   state_nx = bsrs_pkg::ST_TRAMP;
			bsrs_pkg::ST_TRAMP: state_nx = bsrs_pkg::ST_TUPD;
			bsrs_pkg::ST_TUPD:  state_nx = bsrs_pkg::ST_DIVGO;
			bsrs_pkg::ST_DIVGO: state_nx = bsrs_pkg::ST_DIVWAIT;
			bsrs_pkg::ST_DIVWAIT: begin
				if (!sts.div_busy) state_nx = bsrs_pkg::ST_EMIT;
			end
			bsrs_pkg::ST_EMIT: begin
				if (sts.out_free) state_nx = bsrs_pkg::ST_IDLE;
			end
			default: state_nx = bsrs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			bsrs_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			bsrs_pkg::ST_DECODE: begin
				if (sts.op == bsrs_pkg::OP_START) begin
					cmd.set_started = !sts.started;
					cmd.fill_init   = !sts.started && sts.profile;
				end
				cmd.clear = sts.op == bsrs_pkg::OP_STOP;
			end
			bsrs_pkg::ST_FILL:  cmd.fill_we = 1'b1;
			bsrs_pkg::ST_TRD:   cmd.rd      = 1'b1;
			bsrs_pkg::ST_TRAMP: cmd.ramp    = 1'b1;
			bsrs_pkg::ST_TUPD:  cmd.upd     = 1'b1;
			bsrs_pkg::ST_DIVGO: begin
				cmd.div_start = 1'b1;
				cmd.sel_gauge = pass_q || !sts.active;
			end
			bsrs_pkg::ST_DIVWAIT: begin
			end
			bsrs_pkg::ST_EMIT: cmd.out_load = sts.out_free;
			default: begin
			end
		endcase
	end

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while one is in work");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not start");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten before it was taken");

endmodule
